// ----- design/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the hsv to rgb converter modules.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_W = 20;
    localparam int SQ_W  = 9;
    localparam int CH_W  = 8;
    localparam int FRAC_W = 10;
    localparam int TERM_W = 18;

    localparam logic [SQ_W-1:0]   ONE_Q8     = 9'd256;
    localparam logic [FRAC_W-1:0] SECTOR_LEN = 10'd960;
    localparam logic [TERM_W-1:0] TERM_FULL  = 18'd245760;

    // hue >> 7 is wrapped mod 45 (5760 = 45 * 128)
    localparam logic [14:0] HUE_BIAS    = 15'd4140;
    localparam logic [13:0] HUE_DIV     = 14'd45;
    localparam logic [27:0] RECIP_45    = 28'd23302;
    // final scaling by 1 / 60 (2^20 / 60) after dropping 20 bits
    localparam logic [27:0] RECIP_60    = 28'd17477;

    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue_sixteenths;
        logic [SQ_W-1:0]         saturation_q8;
        logic [SQ_W-1:0]         value_q8;
    } t_hsv_req;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            input_invalid;
    } t_rgb_res;

    typedef struct packed {
        t_sector           sector;
        logic [FRAC_W-1:0] frac;
        logic [SQ_W-1:0]   sat;
        logic [SQ_W-1:0]   val;
        logic              invalid;
    } t_mid;

    typedef struct packed {
        logic valid;
        t_mid item;
    } t_mid_push;

    typedef struct packed {
        logic [MID_CW-1:0] count;
        logic              empty;
    } t_q_status;

endpackage

// ----- design/hsvrgb_front.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_front
// Accepts requests, checks range, wraps the hue and splits it into sector
// and fraction over two stages, then pushes into the middle queue.
// ----------------------------------------------------------------------------
module hsvrgb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  hsvrgb_pkg::t_hsv_req  i_req,
    input  hsvrgb_pkg::t_q_status i_q_status,
    output hsvrgb_pkg::t_mid_push o_mid_push
);
    import hsvrgb_pkg::*;

    logic        accept;
    logic [14:0] u_ext;
    logic [13:0] n_u;
    logic [27:0] n_prod;
    logic        n_invalid;

    logic        r1_valid;
    logic [13:0] r1_u;
    logic [7:0]  r1_qq;
    logic [6:0]  r1_lo;
    logic [SQ_W-1:0] r1_sat;
    logic [SQ_W-1:0] r1_val;
    logic        r1_invalid;

    logic [13:0] qq45;
    logic [13:0] rem14;
    logic [6:0]  h6;
    logic [6:0]  base;
    logic [6:0]  sub;
    t_sector     n_sector;

    logic        r2_valid;
    t_mid        r2_item;

    logic [MID_CW+1:0] pending;

    // queue entries plus items still in the two stages
    assign pending = (MID_CW+2)'(i_q_status.count) + (MID_CW+2)'(r1_valid)
                   + (MID_CW+2)'(r2_valid);
    assign full    = (pending >= (MID_CW+2)'(MID_DEPTH));
    assign accept  = push && !full;

    always_comb begin
        u_ext     = {{2{i_req.hue_sixteenths[HUE_W-1]}}, i_req.hue_sixteenths[HUE_W-1:7]}
                  + HUE_BIAS;
        n_u       = u_ext[13:0];
        n_prod    = 28'(n_u) * RECIP_45;
        n_invalid = (i_req.saturation_q8 > ONE_Q8) || (i_req.value_q8 > ONE_Q8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u       <= n_u;
        r1_qq      <= n_prod[27:20];
        r1_lo      <= i_req.hue_sixteenths[6:0];
        r1_sat     <= i_req.saturation_q8;
        r1_val     <= i_req.value_q8;
        r1_invalid <= n_invalid;
    end

    // sector = (hue >> 6) / 15, fraction keeps the remainder and low 6 bits
    always_comb begin
        qq45  = 14'(r1_qq) * HUE_DIV;
        rem14 = r1_u - qq45;
        h6    = {rem14[5:0], r1_lo[6]};
        if (h6 inside {[7'd0:7'd14]}) begin
            n_sector = SEC_RED_YELLOW;
            base     = 7'd0;
        end else if (h6 inside {[7'd15:7'd29]}) begin
            n_sector = SEC_YELLOW_GREEN;
            base     = 7'd15;
        end else if (h6 inside {[7'd30:7'd44]}) begin
            n_sector = SEC_GREEN_CYAN;
            base     = 7'd30;
        end else if (h6 inside {[7'd45:7'd59]}) begin
            n_sector = SEC_CYAN_BLUE;
            base     = 7'd45;
        end else if (h6 inside {[7'd60:7'd74]}) begin
            n_sector = SEC_BLUE_MAGENTA;
            base     = 7'd60;
        end else begin
            n_sector = SEC_MAGENTA_RED;
            base     = 7'd75;
        end
        sub = h6 - base;
    end

    always_ff @(posedge i_clk) begin
        r2_item.sector  <= n_sector;
        r2_item.frac    <= {sub[3:0], r1_lo[5:0]};
        r2_item.sat     <= r1_sat;
        r2_item.val     <= r1_val;
        r2_item.invalid <= r1_invalid;
    end

    assign o_mid_push.valid = r2_valid;
    assign o_mid_push.item  = r2_item;

endmodule

// ----- design/hsvrgb_mid_queue.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_mid_queue
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module hsvrgb_mid_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvrgb_pkg::t_mid_push i_push,
    input  logic                  i_take,
    output hsvrgb_pkg::t_q_status o_status,
    output hsvrgb_pkg::t_mid      o_head
);
    import hsvrgb_pkg::*;

    t_mid              r_mem [MID_DEPTH];
    logic [MID_AW-1:0] r_wr;
    logic [MID_AW-1:0] r_rd;
    logic [MID_CW-1:0] r_count;
    logic [MID_CW-1:0] n_count;

    always_comb begin
        n_count = r_count + MID_CW'(i_push.valid) - MID_CW'(i_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + MID_AW'(1);
            end
            if (i_take) begin
                r_rd <= r_rd + MID_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

endmodule

// ----- design/hsvrgb_back.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_back
// Forms the three hsv terms, applies the sector permutation, scales each
// channel by 255 and writes the result into the output queue.
// ----------------------------------------------------------------------------
module hsvrgb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvrgb_pkg::t_mid      i_head,
    input  logic                  i_head_empty,
    output logic                  o_take,
    input  logic                  pop,
    output logic                  empty,
    output hsvrgb_pkg::t_rgb_res  o_rgb
);
    import hsvrgb_pkg::*;

    logic [OUT_CW:0]     inflight;
    logic [TERM_W-1:0]   sf;
    logic [TERM_W-1:0]   sg;
    logic [FRAC_W-1:0]   comp;
    logic [SQ_W-1:0]     one_minus_s;
    logic [TERM_W-1:0]   x1;
    logic [TERM_W-1:0]   x2;
    logic [TERM_W-1:0]   x3;
    logic [TERM_W-1:0]   n_xr;
    logic [TERM_W-1:0]   n_xg;
    logic [TERM_W-1:0]   n_xb;

    logic                r_a_valid;
    logic [TERM_W-1:0]   r_a_x [3];
    logic [SQ_W-1:0]     r_a_val;
    logic                r_a_inv;

    logic                r_b_valid;
    logic [26:0]         r_b_n [3];
    logic                r_b_inv;

    logic                r_c_valid;
    logic [13:0]         r_c_y [3];
    logic                r_c_inv;

    logic [34:0]         p [3];
    logic [27:0]         q [3];
    t_rgb_res            n_res;

    t_rgb_res            r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]   r_wr;
    logic [OUT_AW-1:0]   r_rd;
    logic [OUT_CW-1:0]   r_count;
    logic [OUT_CW-1:0]   n_count;
    logic                out_pop;

    // issue only when the output queue has room for everything in flight
    assign inflight = (OUT_CW+1)'(r_count) + (OUT_CW+1)'(r_a_valid)
                    + (OUT_CW+1)'(r_b_valid) + (OUT_CW+1)'(r_c_valid);
    assign o_take   = !i_head_empty && (inflight < (OUT_CW+1)'(OUT_DEPTH));

    always_comb begin
        comp        = SECTOR_LEN - i_head.frac;
        sf          = TERM_W'(i_head.sat) * TERM_W'(i_head.frac);
        sg          = TERM_W'(i_head.sat) * TERM_W'(comp);
        one_minus_s = ONE_Q8 - i_head.sat;
        x1          = TERM_W'(one_minus_s) * TERM_W'(SECTOR_LEN);
        x2          = TERM_FULL - sf;
        x3          = TERM_FULL - sg;
        case (i_head.sector)
            SEC_RED_YELLOW: begin
                n_xr = TERM_FULL; n_xg = x3;        n_xb = x1;
            end
            SEC_YELLOW_GREEN: begin
                n_xr = x2;        n_xg = TERM_FULL; n_xb = x1;
            end
            SEC_GREEN_CYAN: begin
                n_xr = x1;        n_xg = TERM_FULL; n_xb = x3;
            end
            SEC_CYAN_BLUE: begin
                n_xr = x1;        n_xg = x2;        n_xb = TERM_FULL;
            end
            SEC_BLUE_MAGENTA: begin
                n_xr = x3;        n_xg = x1;        n_xb = TERM_FULL;
            end
            default: begin
                n_xr = TERM_FULL; n_xg = x1;        n_xb = x2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= o_take;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x[0] <= n_xr;
        r_a_x[1] <= n_xg;
        r_a_x[2] <= n_xb;
        r_a_val  <= i_head.val;
        r_a_inv  <= i_head.invalid;
        r_b_inv  <= r_a_inv;
        r_c_inv  <= r_b_inv;
    end

    // one lane per channel: v * term, then * 255 >> 20, then / 60
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_b_n[ch] <= 27'(r_a_val) * 27'(r_a_x[ch]);
            r_c_y[ch] <= p[ch][33:20];
        end
        always_comb begin
            p[ch] = {r_b_n[ch], 8'd0} - 35'(r_b_n[ch]);
            q[ch] = 28'(r_c_y[ch]) * RECIP_60;
        end
    end

    always_comb begin
        if (r_c_inv) begin
            n_res               = '0;
            n_res.input_invalid = 1'b1;
        end else begin
            n_res.red           = q[0][27:20];
            n_res.green         = q[1][27:20];
            n_res.blue          = q[2][27:20];
            n_res.input_invalid = 1'b0;
        end
    end

    assign out_pop = pop && !empty;

    always_comb begin
        n_count = r_count + OUT_CW'(r_c_valid) - OUT_CW'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (r_c_valid) begin
                r_wr <= r_wr + OUT_AW'(1);
            end
            if (out_pop) begin
                r_rd <= r_rd + OUT_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_mem[r_wr] <= n_res;
        end
    end

    assign empty = (r_count == '0);
    assign o_rgb = r_mem[r_rd];

endmodule

// ----- design/hsv_to_rgb_converter_unit.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Converts one hsv pixel to 8-bit rgb per clock, while pop keeps up, through a queued pipeline.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock and one result leaves per clock as long as
// pop keeps up; the arithmetic is fully pipelined, so the sustained rate is
// one item per cycle. The first front stage (hue wrap) loads at the edge
// that accepts a request; then come the second front stage (sector split),
// the write into the middle queue, three multiply stages and the write into
// the 8-entry output queue, whose head can then be popped. An item can wait
// in the middle queue while the back holds off. full rises when the 4-entry
// middle queue plus the two front stages hold four items; the back stops
// taking from the middle queue when the output queue plus its three stages
// would exceed eight items.
module hsv_to_rgb_converter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  hsvrgb_pkg::t_hsv_req i_hsv,
    output logic                 empty,
    input  logic                 pop,
    output hsvrgb_pkg::t_rgb_res o_rgb
);
    import hsvrgb_pkg::*;

    t_mid_push mid_push;
    t_q_status mid_status;
    t_mid      mid_head;
    logic      mid_take;

    hsvrgb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_hsv),
        .i_q_status (mid_status),
        .o_mid_push (mid_push)
    );

    hsvrgb_mid_queue u_mid_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (mid_push),
        .i_take   (mid_take),
        .o_status (mid_status),
        .o_head   (mid_head)
    );

    hsvrgb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (mid_head),
        .i_head_empty (mid_status.empty),
        .o_take       (mid_take),
        .pop          (pop),
        .empty        (empty),
        .o_rgb        (o_rgb)
    );

    // front credit must keep the middle queue from overflowing
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_push.valid |-> (mid_status.count < MID_CW'(MID_DEPTH)))
        else $error("middle queue written while full");

    a_mid_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_take |-> !mid_status.empty)
        else $error("middle queue read while empty");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rgb.input_invalid) |->
            (o_rgb.red == '0 && o_rgb.green == '0 && o_rgb.blue == '0))
        else $error("invalid pixel with nonzero channels");

endmodule
